[sv/assert_macros.svh]
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every clock outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[sv/lru_kvc_pkg.sv]
package lru_kvc_pkg;

    localparam int CAP_WIDTH = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef logic [1:0] state_t;

endpackage

[sv/lru_key_value_cache_unit.sv]
// Fully associative key/value cache with least-recently-used replacement. A request is
// taken when start is high and busy is low; busy then stays high through a sweep that
// reads the key and value memory one entry per cycle through registered read ports,
// followed by an update cycle that writes the memory where needed and ages, all at once,
// the recency ranks of the valid entries more recent than the touched or inserted one. The
// result (hit, read_value) appears on done for exactly one cycle as busy falls and cannot be
// held off by the receiver; a new request may be issued in that same cycle, but no request
// is taken while busy is high. A get that misses and every put return read_value zero. The
// cache is empty after reset and capacity resets to 16; write capacity only while busy is
// low and no result is pending.
`include "assert_macros.svh"

module lru_key_value_cache_unit
    import lru_kvc_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   mode,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   cfg_wr_en,
    input  logic [CAP_WIDTH-1:0]   cfg_wr_data,
    output logic                   done,
    output logic                   hit,
    output logic [VALUE_WIDTH-1:0] read_value
);

    localparam int AW = $clog2(ENTRIES);
    localparam int RW = AW;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_WIDTH) ? OW : CAP_WIDTH;

    localparam state_t ST_IDLE   = 2'd0;
    localparam state_t ST_SEARCH = 2'd1;
    localparam state_t ST_UPDATE = 2'd2;

    logic [KEY_WIDTH-1:0]   key_mem [ENTRIES];
    logic [VALUE_WIDTH-1:0] val_mem [ENTRIES];

    state_t                 state_reg;
    logic [CAP_WIDTH-1:0]   cap_reg;
    logic                   mode_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    logic [AW-1:0]          idx_reg;
    logic                   issue_done_reg;
    logic                   rd_vld_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic [KEY_WIDTH-1:0]   key_rd_reg;
    logic [VALUE_WIDTH-1:0] val_rd_reg;

    logic                   found_reg;
    logic [AW-1:0]          slot_reg;
    logic [RW-1:0]          hit_rank_reg;
    logic [VALUE_WIDTH-1:0] hit_val_reg;
    logic                   any_reg;
    logic [AW-1:0]          worst_reg;
    logic [RW-1:0]          worst_rank_reg;
    logic                   free_any_reg;
    logic [AW-1:0]          free_reg;

    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     valid_next;
    logic [RW-1:0]          rank_reg  [ENTRIES];
    logic [RW-1:0]          rank_next [ENTRIES];
    logic [OW-1:0]          occ_reg;
    logic [OW-1:0]          occ_next;

    logic                   done_reg;
    logic                   hit_reg;
    logic [VALUE_WIDTH-1:0] read_value_reg;

    logic                   accept;
    logic                   last_rd;
    logic [CW-1:0]          cap_ext;
    logic [CW-1:0]          cap_eff;
    logic                   full;
    logic                   do_touch;
    logic [AW-1:0]          tslot;
    logic [RW:0]            thr;
    logic                   we_key;
    logic                   we_val;
    logic [AW-1:0]          wr_addr;
    logic                   ins_new;

    assign accept  = start && (state_reg == ST_IDLE);
    assign last_rd = rd_vld_reg && (rd_idx_reg == AW'(ENTRIES - 1));
    assign busy    = (state_reg != ST_IDLE);

    // clamp capacity to 1..ENTRIES
    always_comb
    begin
        cap_ext = CW'(cap_reg);
        if (cap_ext == '0)
            cap_eff = CW'(1);
        else if (cap_ext > CW'(ENTRIES))
            cap_eff = CW'(ENTRIES);
        else
            cap_eff = cap_ext;
        full = (CW'(occ_reg) >= cap_eff);
    end

    // update decision
    always_comb
    begin
        do_touch = 1'b0;
        tslot    = slot_reg;
        thr      = {1'b0, hit_rank_reg};
        we_key   = 1'b0;
        we_val   = 1'b0;
        wr_addr  = slot_reg;
        ins_new  = 1'b0;
        if (state_reg == ST_UPDATE)
        begin
            if (found_reg)
            begin
                do_touch = 1'b1;
                we_val   = (mode_reg == MODE_PUT);
            end
            else if (mode_reg == MODE_PUT)
            begin
                if (full && any_reg)
                begin
                    do_touch = 1'b1;
                    tslot    = worst_reg;
                    thr      = {1'b0, worst_rank_reg};
                    we_key   = 1'b1;
                    we_val   = 1'b1;
                    wr_addr  = worst_reg;
                end
                else if (free_any_reg)
                begin
                    do_touch = 1'b1;
                    tslot    = free_reg;
                    thr      = (RW + 1)'(ENTRIES);
                    we_key   = 1'b1;
                    we_val   = 1'b1;
                    wr_addr  = free_reg;
                    ins_new  = 1'b1;
                end
            end
        end
    end

    // age every rank below the threshold, move the touched entry to the front
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
            if (do_touch)
            begin
                if (valid_reg[j] && ({1'b0, rank_reg[j]} < thr))
                    rank_next[j] = rank_reg[j] + RW'(1);
                if (tslot == AW'(j))
                    rank_next[j] = '0;
            end
        end
        if (ins_new)
        begin
            valid_next[free_reg] = 1'b1;
            occ_next             = occ_reg + OW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_key)
            key_mem[wr_addr] <= key_reg;
        if (we_val)
            val_mem[wr_addr] <= value_reg;
        key_rd_reg <= key_mem[idx_reg];
        val_rd_reg <= val_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            any_reg        <= 1'b0;
            free_any_reg   <= 1'b0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            done_reg       <= 1'b0;
            for (int j = 0; j < ENTRIES; j++)
                rank_reg[j] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int j = 0; j < ENTRIES; j++)
                rank_reg[j] <= rank_next[j];
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg      <= ST_SEARCH;
                        idx_reg        <= '0;
                        issue_done_reg <= 1'b0;
                        rd_vld_reg     <= 1'b0;
                        found_reg      <= 1'b0;
                        any_reg        <= 1'b0;
                        free_any_reg   <= 1'b0;
                    end
                end
                ST_SEARCH:
                begin
                    // issue reads one entry a cycle
                    rd_vld_reg <= !issue_done_reg;
                    rd_idx_reg <= idx_reg;
                    if (!issue_done_reg)
                    begin
                        if (idx_reg == AW'(ENTRIES - 1))
                            issue_done_reg <= 1'b1;
                        else
                            idx_reg <= idx_reg + AW'(1);
                    end
                    // check returned entry
                    if (rd_vld_reg)
                    begin
                        if (valid_reg[rd_idx_reg])
                        begin
                            if (!found_reg && (key_rd_reg == key_reg))
                            begin
                                found_reg    <= 1'b1;
                                slot_reg     <= rd_idx_reg;
                                hit_rank_reg <= rank_reg[rd_idx_reg];
                                hit_val_reg  <= val_rd_reg;
                            end
                            if (!any_reg || (rank_reg[rd_idx_reg] > worst_rank_reg))
                            begin
                                any_reg        <= 1'b1;
                                worst_reg      <= rd_idx_reg;
                                worst_rank_reg <= rank_reg[rd_idx_reg];
                            end
                        end
                        else if (!free_any_reg)
                        begin
                            free_any_reg <= 1'b1;
                            free_reg     <= rd_idx_reg;
                        end
                    end
                    if (last_rd)
                        state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // hold request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            value_reg <= value;
        end
        if (state_reg == ST_UPDATE)
        begin
            hit_reg        <= found_reg;
            read_value_reg <= (found_reg && (mode_reg == MODE_GET)) ? hit_val_reg : '0;
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    `ASSERT_CLK(a_done_after_update, done_reg |-> $past(state_reg == ST_UPDATE),
        "result strobe without update cycle")
    `ASSERT_CLK(a_occ_matches_valid, $countones(valid_reg) == occ_reg,
        "occupancy differs from valid entry count")
    `ASSERT_NEVER(a_miss_value, done_reg && !hit_reg && (read_value_reg != '0),
        "nonzero value on miss")
    `ASSERT_CLK(a_insert_room, (state_reg == ST_UPDATE) && ins_new |-> (occ_reg < OW'(ENTRIES)),
        "insert into a full store")

endmodule

[verif/tb_lru_key_value_cache_unit.sv]
module tb_lru_key_value_cache_unit;
    import lru_kvc_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int KEY_WIDTH    = 32;
    localparam int VALUE_WIDTH  = 32;
    localparam int PHASE_ITEMS  = 153;
    localparam int POOL_SIZE    = 40;
    localparam int DRAIN_CYCLES = ENTRIES + 6;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {ROW_GET, ROW_PUT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] data;
        bit                     typed;
        bit                     hit;
        logic [VALUE_WIDTH-1:0] rd;
    } dir_row_t;

    typedef struct {
        int                     seq;
        bit                     hit;
        logic [VALUE_WIDTH-1:0] rd;
    } reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   mode = MODE_GET;
    logic [KEY_WIDTH-1:0]   key = '0;
    logic [VALUE_WIDTH-1:0] value = '0;
    logic                   cfg_wr_en = 1'b0;
    logic [CAP_WIDTH-1:0]   cfg_wr_data = '0;
    logic                   done;
    logic                   hit;
    logic [VALUE_WIDTH-1:0] read_value;

    lru_key_value_cache_unit #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [KEY_WIDTH-1:0]   cache_keys [ENTRIES];
    logic [VALUE_WIDTH-1:0] cache_vals [ENTRIES];
    bit                     cache_live [ENTRIES];
    int unsigned            cache_age  [ENTRIES];
    int unsigned            cache_fill = 0;
    logic [CAP_WIDTH-1:0]   cap_setting = CAP_RESET;

    reply_t pending_replies [$];
    reply_t table_replies [int];
    int     accepted_count = 0;
    int     sent_count = 0;
    int     mismatches = 0;
    int     cycle_count = 0;

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_keys[i] = '0;
            cache_vals[i] = '0;
            cache_live[i] = 1'b0;
            cache_age[i]  = 0;
        end
    end

    function automatic int unsigned usable_capacity(input logic [CAP_WIDTH-1:0] c);
        if (c < 1)
            return 1;
        if (c > ENTRIES)
            return ENTRIES;
        return c;
    endfunction

    function automatic void make_newest(input int s);
        int unsigned r;
        r = cache_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (cache_live[i] && cache_age[i] < r)
                cache_age[i]++;
        cache_age[s] = 0;
    endfunction

    function automatic void lru_access(input logic m, input logic [KEY_WIDTH-1:0] k,
                                       input logic [VALUE_WIDTH-1:0] v, output reply_t r);
        int unsigned lim;
        int          slot;
        bit          found;
        int          victim;
        int unsigned oldest;
        bit          any;
        lim = usable_capacity(cap_setting);
        slot = 0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found && cache_live[i] && cache_keys[i] == k)
            begin
                slot = i;
                found = 1'b1;
            end
        end
        r.seq = 0;
        r.hit = found;
        r.rd = '0;
        if (m == MODE_GET)
        begin
            if (found)
            begin
                r.rd = cache_vals[slot];
                make_newest(slot);
            end
            return;
        end
        if (found)
        begin
            cache_vals[slot] = v;
            make_newest(slot);
            return;
        end
        if (cache_fill >= lim)
        begin
            victim = 0;
            oldest = 0;
            any = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (cache_live[i] && (!any || cache_age[i] > oldest))
                begin
                    victim = i;
                    oldest = cache_age[i];
                    any = 1'b1;
                end
            end
            if (any)
            begin
                cache_keys[victim] = k;
                cache_vals[victim] = v;
                make_newest(victim);
                return;
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!cache_live[i])
            begin
                for (int j = 0; j < ENTRIES; j++)
                    if (cache_live[j])
                        cache_age[j]++;
                cache_live[i] = 1'b1;
                cache_keys[i] = k;
                cache_vals[i] = v;
                cache_age[i] = 0;
                cache_fill++;
                return;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : monitor
        reply_t want;
        reply_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch("result with no request pending", read_value, '0);
                else
                begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    if (table_replies.exists(want.seq))
                        want = table_replies[want.seq];
                    if (hit !== want.hit)
                        report_mismatch("hit", {31'b0, hit}, {31'b0, want.hit});
                    if (read_value !== want.rd)
                        report_mismatch("read_value", read_value, want.rd);
                end
            end
            if (cfg_wr_en)
                cap_setting = cfg_wr_data;
            if (start && !busy)
            begin
                lru_access(mode, key, value, pred);
                pred.seq = accepted_count;
                accepted_count++;
                pending_replies.insert(pending_replies.size(), pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic m, input logic [KEY_WIDTH-1:0] k,
                                input logic [VALUE_WIDTH-1:0] v);
        start <= 1'b1;
        mode  <= m;
        key   <= k;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_replies.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] c);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    dir_row_t dir_rows [25] = '{
        '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_PUT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A},
        '{ROW_PUT, 32'h0000_0001, 32'h1357_9BDF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'h0000_0002, 32'h2468_ACE0, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'h0000_0003, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'h0000_0004, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'h0000_0004, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_PUT, 32'h0000_0005, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, 32'h0000_0000, 32'h0000_0010, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
    };

    logic [CAP_WIDTH-1:0] phase_caps [10] = '{5'd16, 5'd1, 5'd0, 5'd6, 5'd31,
                                              5'd3, 5'd2, 5'd12, 5'd20, 5'd16};

    initial
    begin : stimulus
        logic [KEY_WIDTH-1:0]   key_pool [POOL_SIZE];
        int                     pool_used;
        int                     remaining;
        int                     burst;
        int                     pick;
        logic                   req_mode;
        logic [KEY_WIDTH-1:0]   req_key;
        logic [VALUE_WIDTH-1:0] req_value;

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_capacity(dir_rows[i].data[CAP_WIDTH-1:0]);
            else
            begin
                if (dir_rows[i].typed)
                    table_replies[sent_count] = '{sent_count, dir_rows[i].hit, dir_rows[i].rd};
                send_request(dir_rows[i].kind == ROW_PUT ? MODE_PUT : MODE_GET,
                             dir_rows[i].key, dir_rows[i].data);
            end
        end

        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            pool_used = usable_capacity(phase_caps[p]) + $urandom_range(1, 6);
            remaining = PHASE_ITEMS;
            while (remaining > 0)
            begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && remaining > 0)
                begin
                    req_mode = ($urandom_range(0, 9) < 5) ? MODE_PUT : MODE_GET;
                    if ($urandom_range(0, 19) < 17)
                        req_key = key_pool[$urandom_range(0, pool_used - 1)];
                    else
                        req_key = $urandom;
                    if ($urandom_range(0, 15) == 0)
                        req_value = $urandom_range(0, 1) ? '1 : '0;
                    else
                        req_value = $urandom;
                    send_request(req_mode, req_key, req_value);
                    burst--;
                    remaining--;
                end
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    drain_replies();
                else if (pick >= 5)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
            end
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/lru_kvc_pkg.sv
sv/lru_key_value_cache_unit.sv
verif/tb_lru_key_value_cache_unit.sv
